>>> design/spfd_pkg.sv
// Package for the sync-prefix frame deframer: parser phase type,
// prefix bytes, result record and register reset value.
// No dependencies.
`default_nettype none

package spfd_pkg;

  typedef enum logic [2:0] {
    PH_PREFIX  = 3'd0,
    PH_COMMAND = 3'd1,
    PH_REQUEST = 3'd2,
    PH_LENGTH  = 3'd3,
    PH_DATA    = 3'd4
  } phase_t;

  localparam logic [7:0]  SYNC_0         = 8'h5A;  // 'Z'
  localparam logic [7:0]  SYNC_1         = 8'h50;  // 'P'
  localparam logic [7:0]  SYNC_2         = 8'h42;  // 'B'
  localparam logic [15:0] POS_PREFIX_END = 16'd2;
  localparam logic [15:0] MAX_LEN_RST    = 16'd255;

  typedef struct packed {
    logic        has_payload;
    logic        last;
    logic [15:0] byte_position;
    logic [7:0]  payload_byte;
    logic [15:0] frame_length;
    logic [15:0] request_tag;
    logic [7:0]  command_code;
  } res_t;

  function automatic logic [7:0] sync_byte(input logic [1:0] idx);
    logic [7:0] s;
    case (idx)
      2'd0:    s = SYNC_0;
      2'd1:    s = SYNC_1;
      2'd2:    s = SYNC_2;
      default: s = SYNC_0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> design/sync_prefix_frame_deframer_core.sv
// Sync-prefix frame deframer, top level.
// Depends on spfd_pkg (phase type, prefix bytes, result record).
//
// Usage:
//   in_*   : one received byte per transaction (in_tdata).
//   out_*  : one result per payload byte, or one completion result for an
//            empty frame. tdata carries the header fields, the payload byte
//            and its position; tuser marks a payload byte; tlast marks the
//            result that completes the frame.
//   cfg_*  : write of max_payload_length; longer frames are dropped without
//            any result. Write only while the block is idle.
// Throughput: one byte per cycle while in_tready is high. The parser state is
// updated in the cycle a byte is accepted, and its result is registered in the
// output register, or in the skid register while the output is stalled.
// A two-entry output stage (output register plus skid register) lets a byte
// be accepted while a result waits; in_tready drops only when both hold a
// result, and recovers the cycle after out_tready returns.
// Reset (rst_n low, synchronous) returns the parser to prefix search, clears
// the header fields and the output stage, and sets max_payload_length to 255.
`default_nettype none

module sync_prefix_frame_deframer_core (
  input  wire         clk,
  input  wire         rst_n,
  // configuration
  input  wire         cfg_wr_en,
  input  wire  [15:0] cfg_wr_data,   // max_payload_length
  // received bytes
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,      // [7:0] rx_byte
  // results
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,     // [7:0] command_code, [23:8] request_tag,
                                     // [39:24] frame_length, [47:40] payload_byte,
                                     // [63:48] byte_position
  output logic [0:0]  out_tuser,     // [0] has_payload
  output logic        out_tlast      // last
);
  import spfd_pkg::*;

  logic [15:0] max_len_r;

  phase_t      phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] req_r, req_nxt;
  logic [15:0] len_r, len_nxt;

  logic        in_fire;
  logic [15:0] len_shift;
  logic [16:0] pos_inc;
  logic        data_fin;
  logic        pos_hi;

  logic        res_vld;
  res_t        res;

  logic        out_vld_r, skid_vld_r;
  res_t        out_r, skid_r;

  assign in_tready = ~skid_vld_r;
  assign in_fire   = in_tvalid & in_tready;
  assign len_shift = {len_r[7:0], in_tdata};
  assign pos_inc   = {1'b0, pos_r} + 17'd1;
  assign data_fin  = pos_inc >= {1'b0, len_r};
  assign pos_hi    = pos_r != 16'd0;   // second byte of a 16-bit field

  // next state
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    cmd_nxt   = cmd_r;
    req_nxt   = req_r;
    len_nxt   = len_r;
    if (in_fire) begin
      case (phase_r)
        PH_PREFIX: begin
          if (pos_r > POS_PREFIX_END || in_tdata != sync_byte(pos_r[1:0])) begin
            pos_nxt = '0;
            cmd_nxt = '0;
            req_nxt = '0;
            len_nxt = '0;
          end else if (pos_r == POS_PREFIX_END) begin
            phase_nxt = PH_COMMAND;
            pos_nxt   = '0;
          end else begin
            pos_nxt = pos_inc[15:0];
          end
        end
        PH_COMMAND: begin
          cmd_nxt   = in_tdata;
          req_nxt   = '0;
          pos_nxt   = '0;
          phase_nxt = PH_REQUEST;
        end
        PH_REQUEST: begin
          req_nxt = {req_r[7:0], in_tdata};
          if (pos_hi) begin
            phase_nxt = PH_LENGTH;
            pos_nxt   = '0;
            len_nxt   = '0;
          end else begin
            pos_nxt = pos_inc[15:0];
          end
        end
        PH_LENGTH: begin
          len_nxt = len_shift;
          if (pos_hi) begin
            if (len_shift > max_len_r || len_shift == 16'd0) begin
              // dropped, or empty frame completed
              phase_nxt = PH_PREFIX;
              pos_nxt   = '0;
              cmd_nxt   = '0;
              req_nxt   = '0;
              len_nxt   = '0;
            end else begin
              phase_nxt = PH_DATA;
              pos_nxt   = '0;
            end
          end else begin
            pos_nxt = pos_inc[15:0];
          end
        end
        PH_DATA: begin
          if (data_fin) begin
            phase_nxt = PH_PREFIX;
            pos_nxt   = '0;
            cmd_nxt   = '0;
            req_nxt   = '0;
            len_nxt   = '0;
          end else begin
            pos_nxt = pos_inc[15:0];
          end
        end
        default: begin
          phase_nxt = PH_PREFIX;
          pos_nxt   = '0;
          cmd_nxt   = '0;
          req_nxt   = '0;
          len_nxt   = '0;
        end
      endcase
    end
  end

  // result of the accepted byte
  always_comb begin
    res_vld           = 1'b0;
    res.command_code  = cmd_r;
    res.request_tag   = req_r;
    res.frame_length  = len_r;
    res.payload_byte  = in_tdata;
    res.byte_position = pos_r;
    res.has_payload   = 1'b1;
    res.last          = data_fin;
    case (phase_r)
      PH_LENGTH: begin
        if (pos_hi && len_shift == 16'd0) begin
          res_vld           = in_fire;
          res.frame_length  = len_shift;
          res.payload_byte  = '0;
          res.byte_position = '0;
          res.has_payload   = 1'b0;
          res.last          = 1'b1;
        end
      end
      PH_DATA: res_vld = in_fire;
      default: res_vld = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
      phase_r   <= PH_PREFIX;
      pos_r     <= '0;
      cmd_r     <= '0;
      req_r     <= '0;
      len_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      cmd_r   <= cmd_nxt;
      req_r   <= req_nxt;
      len_r   <= len_nxt;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (out_vld_r && !out_tready) begin
        if (res_vld) begin
          skid_vld_r <= 1'b1;
        end
      end else if (skid_vld_r) begin
        // skid holds the older result; no new one can arrive (in_tready low)
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= res_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_vld_r && !out_tready) begin
      if (res_vld) begin
        skid_r <= res;
      end
    end else if (skid_vld_r) begin
      out_r <= skid_r;
    end else if (res_vld) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_r.byte_position, out_r.payload_byte, out_r.frame_length,
                       out_r.request_tag, out_r.command_code};
  assign out_tuser  = out_r.has_payload;
  assign out_tlast  = out_r.last;

endmodule

`default_nettype wire
